[rtl/ckvc_pkg.sv]
// Package for the clock-evicting key-value cache.
// Holds sizes, request codes, register addresses and the payload structs.
// No dependencies.
`default_nettype none

package ckvc_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;

   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int SWEEP_W = $clog2(2 * CAPACITY + 1);
   localparam int LIMIT_W = 5;
   localparam int LIM_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_LIMIT = 1'b0;

   // Request codes.
   localparam logic [2:0] REQ_SET    = 3'd0;
   localparam logic [2:0] REQ_GET    = 3'd1;
   localparam logic [2:0] REQ_DELETE = 3'd2;
   localparam logic [2:0] REQ_UPDATE = 3'd3;
   localparam logic [2:0] REQ_CLEAR  = 3'd4;

   // Result status codes.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   typedef struct packed {
      logic [2:0]            req_type;
      logic [KEY_BITS-1:0]   req_key;
      logic [VALUE_BITS-1:0] req_value;
   } req_item_type;

   typedef struct packed {
      logic                  status;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } rsp_item_type;

endpackage

`default_nettype wire

[rtl/ckvc_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// Used for the key and value stores of the cache. No dependencies.
`default_nettype none

module ckvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/clock_evicting_key_value_cache.sv]
// Top level of the clock-evicting key-value cache: control sequencer, slot flags,
// configuration register and output register. Depends on ckvc_pkg and ckvc_ram.
//
// Usage
//   Requests arrive on the req_ channel (valid/stall); one result per request
//   leaves on the rsp_ channel. A transfer happens at a rising edge where valid
//   is high and stall is low. Requests are set, get, delete, update and clear.
//   The capacity_limit register sits at byte address 0 of the APB-style port
//   and may be written only while the cache is idle.
//
//   One request is processed at a time. Keys live in a synchronous RAM, so a
//   lookup scans it one slot per cycle and stops at the first matching slot.
//   A request passes through the accept, scan, decide, write/read and result
//   steps. A set of a new key at the limit adds a clock sweep of one slot per
//   cycle; the eviction write takes the place of the fill.
//
//   The result sits in an output register; the next request is accepted while
//   a stalled result waits, and only the following result holds the sequencer.
//   Reset empties the table, returns the hand to slot 0 and sets the limit to 16.
`default_nettype none

module clock_evicting_key_value_cache
   import ckvc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_item_type            req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_item_type                 rsp_data,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   paddr,
   input  wire logic [CSR_DATA_W-1:0]   pwdata,
   output logic      [CSR_DATA_W-1:0]   prdata,
   output logic                         pready
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SWEEP  = 3'd3;
   localparam logic [2:0] ST_EVICT  = 3'd4;
   localparam logic [2:0] ST_FILL   = 3'd5;
   localparam logic [2:0] ST_GET    = 3'd6;
   localparam logic [2:0] ST_RESP   = 3'd7;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   logic [2:0]          state_ff, state_in;
   req_item_type        req_ff, req_in;
   rsp_item_type        res_ff, res_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    hand_ff, hand_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CAPACITY-1:0] ref_ff, ref_in;
   logic [SWEEP_W-1:0]  sweep_ff, sweep_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;

   logic                req_xfer;
   logic                csr_write;
   logic                csr_hit;
   logic [LIM_W-1:0]    lim_raw;
   logic [LIM_W-1:0]    lim_eff;
   logic                at_limit;
   logic                free_found;
   logic [IDX_W-1:0]    free_idx;
   logic [IDX_W-1:0]    hand_next;

   logic                key_wr_en, val_wr_en;
   logic [IDX_W-1:0]    key_wr_addr, val_wr_addr, key_rd_addr;
   logic [KEY_BITS-1:0] key_rd_data;
   logic [VALUE_BITS-1:0] val_rd_data;

   ckvc_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (req_ff.req_key),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   ckvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (req_ff.req_value),
      .rd_addr (slot_ff),
      .rd_data (val_rd_data)
   );

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_LIMIT);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? CSR_DATA_W'(limit_ff) : '0;
   assign limit_in  = csr_write ? pwdata[LIMIT_W-1:0] : limit_ff;

   // A limit of zero acts as one, a limit above the table size as the table size.
   assign lim_raw = LIM_W'(limit_ff);
   always_comb begin
      lim_eff = lim_raw;
      if (lim_raw == '0) begin
         lim_eff = LIM_W'(1);
      end else if (lim_raw > LIM_W'(CAPACITY)) begin
         lim_eff = LIM_W'(CAPACITY);
      end
   end
   assign at_limit = (LIM_W'(count_ff) >= lim_eff);

   // Lowest-numbered free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign hand_next = (hand_ff == LAST_IDX) ? '0 : hand_ff + 1'b1;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign key_rd_addr = (state_ff == ST_SWEEP) ? hand_ff : scan_idx_ff[IDX_W-1:0];
   assign key_wr_addr = (state_ff == ST_EVICT) ? slot_ff : free_idx;
   assign val_wr_addr = (state_ff == ST_FILL) ? free_idx : slot_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      hand_in      = hand_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      ref_in       = ref_ff;
      sweep_in     = sweep_ff;
      key_wr_en    = 1'b0;
      val_wr_en    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_in      = req_data;
               res_in      = '0;
               scan_idx_in = '0;
               if (req_data.req_type == REQ_CLEAR) begin
                  valid_in = '0;
                  ref_in   = '0;
                  count_in = '0;
                  hand_in  = '0;
                  state_in = ST_RESP;
               end else if (req_data.req_type > REQ_CLEAR) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         // Issue one key read per cycle and compare the key read the cycle before.
         ST_SCAN: begin
            if (scan_idx_ff != CNT_W'(CAPACITY)) begin
               scan_idx_in = scan_idx_ff + 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
            end
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff] && (key_rd_data == req_ff.req_key)) begin
                  found_in   = 1'b1;
                  slot_in    = cmp_idx_ff;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_DECIDE;
               end else if (cmp_idx_ff == LAST_IDX) begin
                  found_in   = 1'b0;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            state_in = ST_RESP;
            case (req_ff.req_type)
               REQ_SET: begin
                  if (found_ff) begin
                     val_wr_en       = 1'b1;
                     ref_in[slot_ff] = 1'b1;
                  end else if (at_limit) begin
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end else begin
                     state_in = ST_FILL;
                  end
               end
               REQ_GET: begin
                  if (found_ff) begin
                     ref_in[slot_ff] = 1'b1;
                     state_in        = ST_GET;
                  end else begin
                     res_in.status = STATUS_NOT_FOUND;
                  end
               end
               REQ_DELETE: begin
                  if (found_ff) begin
                     valid_in[slot_ff] = 1'b0;
                     ref_in[slot_ff]   = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     res_in.status = STATUS_NOT_FOUND;
                  end
               end
               REQ_UPDATE: begin
                  if (found_ff) begin
                     val_wr_en       = 1'b1;
                     ref_in[slot_ff] = 1'b1;
                  end else begin
                     res_in.status = STATUS_NOT_FOUND;
                  end
               end
               default: begin
               end
            endcase
         end

         // One hand step per cycle; the key RAM reads the slot under the hand
         // so that a victim's key is ready in the next cycle.
         ST_SWEEP: begin
            hand_in = hand_next;
            if (valid_ff[hand_ff] && !ref_ff[hand_ff]) begin
               slot_in  = hand_ff;
               state_in = ST_EVICT;
            end else begin
               if (valid_ff[hand_ff]) begin
                  ref_in[hand_ff] = 1'b0;
               end
               if (sweep_ff == SWEEP_W'(2 * CAPACITY)) begin
                  state_in = ST_FILL;
               end else begin
                  sweep_in = sweep_ff + 1'b1;
               end
            end
         end

         // The new key takes the victim's slot, so the entry count is unchanged.
         ST_EVICT: begin
            key_wr_en          = 1'b1;
            val_wr_en          = 1'b1;
            ref_in[slot_ff]    = 1'b1;
            res_in.evicted     = 1'b1;
            res_in.evicted_key = key_rd_data;
            state_in           = ST_RESP;
         end

         ST_FILL: begin
            if (free_found) begin
               key_wr_en          = 1'b1;
               val_wr_en          = 1'b1;
               valid_in[free_idx] = 1'b1;
               ref_in[free_idx]   = 1'b1;
               count_in           = count_ff + 1'b1;
            end
            state_in = ST_RESP;
         end

         ST_GET: begin
            res_in.read_value = val_rd_data;
            state_in          = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         hand_ff      <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         ref_ff       <= '0;
         sweep_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         hand_ff      <= hand_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         ref_ff       <= ref_in;
         sweep_ff     <= sweep_in;
         limit_ff     <= limit_in;
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      cmp_idx_ff  <= cmp_idx_in;
      slot_ff     <= slot_in;
   end

   // The entry count always equals the number of valid slots.
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count differs from number of valid slots");

   // Only a valid slot can carry a reference mark.
   a_ref_implies_valid: assert property (@(posedge clock) disable iff (reset)
      (ref_ff & ~valid_ff) == '0)
      else $error("referenced slot is not valid");

   // An accepted request holds off the next one in the following cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("request accepted while another is in progress");

   // A new result is loaded only when the output register is free or draining.
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("waiting result was overwritten");

   // Neither the key RAM nor the value RAM is written during a lookup scan.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !key_wr_en && !val_wr_en)
      else $error("table written during lookup");

endmodule

`default_nettype wire
